FILE: hdl/frustum_sphere_cull_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frustum sphere cull block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_ASSERT_SVH

// property that holds in the same cycle
`define FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define FSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared widths, types and helpers for the frustum sphere cull pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CFG_NUM    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_SEL_W  = 3;
  localparam int CFG_W      = 64;
  localparam int NUM_PLANES = 6;
  localparam int NUM_COEF   = 4;
  localparam int LAT        = 6;

  localparam int CTR_W  = 32;
  localparam int RAD_W  = 31;
  localparam int A_W    = 33;  // plane coefficient
  localparam int P_W    = 65;  // coefficient times center
  localparam int D_W    = 67;  // signed distance
  localparam int S_W    = 66;  // squared normal length
  localparam int M_W    = 66;  // magnitude of a non-positive distance
  localparam int R2_W   = 62;  // squared radius
  localparam int PP_W   = 132; // full width of both squared terms

  // operand split for the partial products
  localparam int MSPLIT = 34;
  localparam int RSPLIT = 31;

  typedef logic [0:CFG_NUM-1][CFG_W-1:0] cfg_t;
  typedef logic signed [A_W-1:0] coef_t;

  typedef struct packed {
    coef_t a0;
    coef_t a1;
    coef_t a2;
    coef_t a3;
  } plane_t;

  localparam cfg_t CFG_RESET = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  // w row plus or minus another row, exact in 33 bits
  function automatic coef_t plane_coef(logic [31:0] w, logic [31:0] x, logic minus);
    coef_t ws;
    coef_t xs;
    ws = coef_t'($signed(w));
    xs = coef_t'($signed(x));
    return minus ? (ws - xs) : (ws + xs);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fsc_lane.sv
// ----------------------------------------------------------------------------
// fsc_lane
// One plane test: distance, normal length and the exact squared compare,
// spread over five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_lane import fsc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire plane_t                  plane_i,
  input  wire logic signed [CTR_W-1:0] ctr_x_i,
  input  wire logic signed [CTR_W-1:0] ctr_y_i,
  input  wire logic signed [CTR_W-1:0] ctr_z_i,
  input  wire logic [R2_W-1:0]         r2_i,     // aligned with stage C
  output logic                         cull_o
);

  // stage A: products
  logic signed [P_W-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [S_W-1:0] qx_d, qy_d, qz_d;
  logic [S_W-1:0]        qx_q, qy_q, qz_q;
  logic signed [D_W-1:0] t3_d, t3_q;

  assign px_d = plane_i.a0 * ctr_x_i;
  assign py_d = plane_i.a1 * ctr_y_i;
  assign pz_d = plane_i.a2 * ctr_z_i;
  assign qx_d = plane_i.a0 * plane_i.a0;
  assign qy_d = plane_i.a1 * plane_i.a1;
  assign qz_d = plane_i.a2 * plane_i.a2;
  assign t3_d = D_W'(plane_i.a3) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      qx_q <= $unsigned(qx_d);
      qy_q <= $unsigned(qy_d);
      qz_q <= $unsigned(qz_d);
      t3_q <= t3_d;
    end
  end

  // stage B: sums
  logic signed [D_W-1:0] d_d, d_q;
  logic [S_W-1:0]        s_b_d, s_b_q;

  assign d_d   = D_W'(px_q) + D_W'(py_q) + D_W'(pz_q) + t3_q;
  assign s_b_d = qx_q + qy_q + qz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= d_d;
      s_b_q <= s_b_d;
    end
  end

  // stage C: magnitude and plane flags
  logic [M_W-1:0] m_d, m_q;
  logic [S_W-1:0] s_c_q;
  logic           le_d, snz_d, le_c_q, snz_c_q;

  assign m_d   = M_W'(-d_q);
  assign le_d  = d_q[D_W-1] | (d_q == '0);
  assign snz_d = |s_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_d;
      s_c_q   <= s_b_q;
      le_c_q  <= le_d;
      snz_c_q <= snz_d;
    end
  end

  // stage D: partial products of m*m and r2*s
  logic [M_W-MSPLIT-1:0]  mh, sh;
  logic [MSPLIT-1:0]      ml, sl;
  logic [R2_W-RSPLIT-1:0] rh;
  logic [RSPLIT-1:0]      rl;

  assign mh = m_q[M_W-1:MSPLIT];
  assign ml = m_q[MSPLIT-1:0];
  assign sh = s_c_q[S_W-1:MSPLIT];
  assign sl = s_c_q[MSPLIT-1:0];
  assign rh = r2_i[R2_W-1:RSPLIT];
  assign rl = r2_i[RSPLIT-1:0];

  localparam int MLL_W = 2 * MSPLIT;
  localparam int MHL_W = M_W;
  localparam int MHH_W = 2 * (M_W - MSPLIT);
  localparam int RSL_W = RSPLIT + MSPLIT;
  localparam int RSH_W = RSPLIT + S_W - MSPLIT;
  localparam int RHL_W = R2_W - RSPLIT + MSPLIT;
  localparam int RHH_W = R2_W - RSPLIT + S_W - MSPLIT;

  logic [MLL_W-1:0] mll_d, mll_q;
  logic [MHL_W-1:0] mhl_d, mhl_q;
  logic [MHH_W-1:0] mhh_d, mhh_q;
  logic [RSL_W-1:0] rll_d, rll_q;
  logic [RSH_W-1:0] rlh_d, rlh_q;
  logic [RHL_W-1:0] rhl_d, rhl_q;
  logic [RHH_W-1:0] rhh_d, rhh_q;
  logic             le_d_q, snz_d_q;

  assign mll_d = MLL_W'(ml) * MLL_W'(ml);
  assign mhl_d = MHL_W'(mh) * MHL_W'(ml);
  assign mhh_d = MHH_W'(mh) * MHH_W'(mh);
  assign rll_d = RSL_W'(rl) * RSL_W'(sl);
  assign rlh_d = RSH_W'(rl) * RSH_W'(sh);
  assign rhl_d = RHL_W'(rh) * RHL_W'(sl);
  assign rhh_d = RHH_W'(rh) * RHH_W'(sh);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mll_q   <= mll_d;
      mhl_q   <= mhl_d;
      mhh_q   <= mhh_d;
      rll_q   <= rll_d;
      rlh_q   <= rlh_d;
      rhl_q   <= rhl_d;
      rhh_q   <= rhh_d;
      le_d_q  <= le_c_q;
      snz_d_q <= snz_c_q;
    end
  end

  // stage E: recombine partial products
  logic [PP_W-1:0] mm_d, mm_q, rs_d, rs_q;
  logic            le_e_q, snz_e_q;

  // cross term counts twice, hence the extra shift bit
  assign mm_d = (PP_W'(mhh_q) << (2 * MSPLIT)) + (PP_W'(mhl_q) << (MSPLIT + 1))
              + PP_W'(mll_q);
  assign rs_d = (PP_W'(rhh_q) << (RSPLIT + MSPLIT)) + (PP_W'(rhl_q) << RSPLIT)
              + (PP_W'(rlh_q) << MSPLIT) + PP_W'(rll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm_q    <= mm_d;
      rs_q    <= rs_d;
      le_e_q  <= le_d_q;
      snz_e_q <= snz_d_q;
    end
  end

  // a zero normal never culls
  assign cull_o = snz_e_q & le_e_q & (mm_q >= rs_q);

endmodule

`default_nettype wire

FILE: hdl/frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Sphere against six frustum planes taken from a view-projection matrix.
// ----------------------------------------------------------------------------
// An accepted sphere passes lane stages A to E and then the output register before its result is valid.
// Throughput: one sphere per cycle while the output is not stalled; six plane lanes work in parallel.
// The pipeline advances as a whole whenever the output register is empty
// or its result is taken in the same cycle.
// Reset clears all valid bits and loads the identity matrix.
`default_nettype none

module frustum_sphere_cull import fsc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [CTR_W-1:0] center_x_i,
  input  wire logic signed [CTR_W-1:0] center_y_i,
  input  wire logic signed [CTR_W-1:0] center_z_i,
  input  wire logic [RAD_W-1:0]        sphere_radius_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         visible_o
);

  `include "frustum_sphere_cull_assert.svh"

  // matrix registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(CFG_NUM))) begin
      cfg_q[cfg_idx_i[CFG_SEL_W-1:0]] <= cfg_wdata_i;
    end
  end

  // plane coefficients: left, right, bottom, top, far, near
  plane_t plane [NUM_PLANES];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    localparam int  ROW   = p / 2;
    localparam logic MINUS = (p % 2) == 1;
    coef_t coef [NUM_COEF];
    for (genvar c = 0; c < NUM_COEF; c++) begin : g_coef
      assign coef[c] = plane_coef(cfg_q[2*c+1][63:32],
                                  cfg_q[2*c + ROW/2][(ROW%2)*32 +: 32], MINUS);
    end
    assign plane[p] = '{a0: coef[0], a1: coef[1], a2: coef[2], a3: coef[3]};
  end

  // pipeline control
  logic           pipe_en;
  logic [LAT-1:0] vld_q;

  assign pipe_en    = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // squared radius, delayed to meet the lanes at stage D
  logic [R2_W-1:0] r2_d, r2_a_q, r2_b_q, r2_c_q;

  assign r2_d = R2_W'(sphere_radius_i) * R2_W'(sphere_radius_i);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r2_a_q <= r2_d;
      r2_b_q <= r2_a_q;
      r2_c_q <= r2_b_q;
    end
  end

  // plane lanes
  logic [NUM_PLANES-1:0] cull;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fsc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .plane_i (plane[p]),
      .ctr_x_i (center_x_i),
      .ctr_y_i (center_y_i),
      .ctr_z_i (center_z_i),
      .r2_i    (r2_c_q),
      .cull_o  (cull[p])
    );
  end

  // output register
  logic visible_d, visible_q;

  assign visible_d = ~|cull;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      visible_q <= visible_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign visible_o   = visible_q;

  // checks
  `FSC_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0],
                   "accepted sphere did not enter the pipeline")
  `FSC_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(vld_q) && $stable(visible_q),
                   "pipeline moved while stalled")
  `FSC_ASSERT_NEXT(a_cfg_range, cfg_we_i && (cfg_idx_i >= CFG_IDX_W'(CFG_NUM)),
                   $stable(cfg_q), "out of range write changed the matrix")

endmodule

`default_nettype wire

FILE: verif/frustum_sphere_cull_tb.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull_tb
// Drives spheres through the cull pipeline under several view-projection
// matrices and compares every visibility flag against an exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_sphere_cull_tb;
  import fsc_pkg::*;

  localparam int IDLE_PCT   = 27;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic signed [CTR_W-1:0] cz;
    logic [RAD_W-1:0]        rad;
  } sphere_t;

  // Visibility prediction and result store
  class cull_scoreboard;
    logic [CFG_W-1:0] mat_regs [CFG_NUM];
    bit               vis_q[$];
    int               errors;
    int               n_checked;
    int               n_culled;

    function void load_reset();
      for (int i = 0; i < CFG_NUM; i++) mat_regs[i] = CFG_RESET[i];
    endfunction

    function void write_reg(int idx, logic [CFG_W-1:0] val);
      if (idx < CFG_NUM) mat_regs[idx] = val;
    endfunction

    // matrix entry at column c, row r (0=x,1=y,2=z,3=w)
    function logic signed [A_W-1:0] entry(int c, int r);
      logic [CFG_W-1:0] rg;
      rg = mat_regs[2*c + r/2];
      return (r % 2) ? A_W'($signed(rg[63:32])) : A_W'($signed(rg[31:0]));
    endfunction

    function bit sphere_visible(sphere_t s);
      logic signed [A_W-1:0]  a [4];
      logic signed [139:0]    dval, nsq, rsq;
      logic signed [CTR_W:0]  ctr [3];
      ctr[0] = s.cx; ctr[1] = s.cy; ctr[2] = s.cz;
      rsq = 140'(s.rad) * 140'(s.rad);
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < 4; c++)
          a[c] = (p % 2) ? entry(c, 3) - entry(c, p/2) : entry(c, 3) + entry(c, p/2);
        dval = 140'(a[3]) <<< FRAC_BITS;
        nsq  = 0;
        for (int c = 0; c < 3; c++) begin
          dval += 140'(a[c]) * 140'(ctr[c]);
          nsq  += 140'(a[c]) * 140'(a[c]);
        end
        if (nsq != 0 && dval <= 0 && dval * dval >= rsq * nsq) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_sphere(sphere_t s);
      vis_q.push_back(sphere_visible(s));
    endfunction

    function void check_result(bit vis);
      n_checked++;
      if (!vis) n_culled++;
      if (vis_q.size() == 0) report_error($sformatf("unexpected result visible=%0b", vis));
      else begin
        bit e;
        e = vis_q.pop_front();
        if (e !== vis) report_error($sformatf("visible=%0b, expected %0b", vis, e));
      end
    endfunction

    function void report_error(string msg);
      errors++;
      if (errors <= 30) $display("ERROR %0t: %s", $time, msg);
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [CTR_W-1:0] center_x_i = '0;
  logic signed [CTR_W-1:0] center_y_i = '0;
  logic signed [CTR_W-1:0] center_z_i = '0;
  logic [RAD_W-1:0]        sphere_radius_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    visible_o;

  cull_scoreboard sb = new();
  bit  no_idle;       // long stretch without random gaps
  bit  sink_hold;     // receiver holds off
  int  n_sent;
  int  quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frustum_sphere_cull i_dut (.*);

  // Input transfers enter the predictor
  always @(posedge clk_i)
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_sphere('{center_x_i, center_y_i, center_z_i, sphere_radius_i});
      n_sent++;
    end

  // Output transfers are checked
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(visible_o);

  // Receiver readiness
  always @(posedge clk_i)
    out_ready_i <= rst_ni && !sink_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);

  // Watchdog on cycles without any transfer, paused while the receiver holds off
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || sink_hold)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("frustum_sphere_cull: mismatch");
      $finish;
    end
  end

  task automatic write_cfg(int idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IDX_W'(idx);
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // One sphere transfer; valid stays up if another follows without a gap,
  // drain() lowers it after the last one
  task automatic send_sphere(sphere_t s);
    if (!no_idle)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i      <= 1'b1;
    center_x_i      <= s.cx;
    center_y_i      <= s.cy;
    center_z_i      <= s.cz;
    sphere_radius_i <= s.rad;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.vis_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS));
      default: return 32'($signed($urandom_range(0, 40 << FRAC_BITS)) - (20 << FRAC_BITS));
    endcase
  endfunction

  function automatic sphere_t rand_sphere();
    sphere_t s;
    int m;
    m = $urandom_range(5);
    s.cx = rand_coord(m); s.cy = rand_coord(m); s.cz = rand_coord(m);
    case ($urandom_range(3))
      0: s.rad = RAD_W'($urandom());
      1: s.rad = '0;
      default: s.rad = RAD_W'($urandom_range(0, 4 << FRAC_BITS));
    endcase
    return s;
  endfunction

  // Random matrix word pair, small values or full range
  function automatic logic [CFG_W-1:0] rand_word(bit wide_range);
    logic [31:0] lo, hi;
    lo = wide_range ? $urandom() : rand_coord(1);
    hi = wide_range ? $urandom() : rand_coord(1);
    return {hi, lo};
  endfunction

  initial begin
    sphere_t s;
    logic [31:0] xtr [4];
    xtr[0] = 32'h7fffffff; xtr[1] = 32'h80000000; xtr[2] = '0; xtr[3] = 32'hffffffff;
    sb.load_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed spheres under the identity matrix
    send_sphere('{0, 0, 0, 0});
    send_sphere('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff});
    send_sphere('{32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff});
    send_sphere('{32'sh80000000, 32'sh80000000, 32'sh80000000, 0});
    send_sphere('{32'sh00030000, 0, 0, 31'h00020000});   // touching the right plane
    send_sphere('{32'sh00030000, 0, 0, 31'h0001ffff});   // just outside
    send_sphere('{0, 32'shfffd0000, 0, 31'h00020000});
    send_sphere('{0, 0, 32'sh00010000, 0});              // on the near plane, zero radius
    send_sphere('{0, 0, 32'sh00010001, 0});
    send_sphere('{32'shffffffff, 32'sh00000001, 32'shffff0000, 31'h1});
    drain();

    // Zero matrix: all normals zero, nothing culls
    for (int i = 0; i < CFG_NUM; i++) write_cfg(i, '0);
    write_cfg(CFG_NUM + 3, 64'hdeadbeef);  // out of range, ignored
    send_sphere('{32'sh7fffffff, 0, 0, 0});
    send_sphere('{32'sh80000000, 32'sh80000000, 32'sh80000000, 0});
    // Extreme entries
    for (int k = 0; k < 4; k++) begin
      drain();
      for (int i = 0; i < CFG_NUM; i++) write_cfg(i, {xtr[(k+i)%4], xtr[(k+i+1)%4]});
      for (int j = 0; j < 3; j++) send_sphere(rand_sphere());
    end
    drain();

    // Random phases, each with a fresh matrix
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < CFG_NUM; i++)
        if (ph == 0) write_cfg(i, CFG_RESET[i]);
        else write_cfg(i, rand_word(ph % 4 == 3));
      no_idle = (ph == 5);
      if (ph == 7) begin
        // back-pressure: receiver holds off while spheres keep coming
        sink_hold = 1'b1;
        fork
          begin repeat (60) @(posedge clk_i); sink_hold = 1'b0; end
          for (int j = 0; j < 20; j++) send_sphere(rand_sphere());
        join
      end
      for (int j = 0; j < 150; j++) send_sphere(rand_sphere());
      no_idle = 1'b0;
      drain();
    end

    $display("sent %0d and checked %0d spheres over 12 random matrices plus directed cases",
             n_sent, sb.n_checked);
    $display("%0d of them culled", sb.n_culled);
    if (sb.errors == 0 && sb.vis_q.size() == 0) begin
      $display("frustum_sphere_cull: match");
    end else begin
      $display("%0d errors, %0d results missing", sb.errors, sb.vis_q.size());
      $display("frustum_sphere_cull: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fsc_pkg.sv
hdl/fsc_lane.sv
hdl/frustum_sphere_cull.sv
verif/frustum_sphere_cull_tb.sv
